// ===== rtl/core/mfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared constants and types for the mesh frame deframer core and its checker.
// ----------------------------------------------------------------------------
package mfd_pkg;

   localparam int unsigned MAX_FRAME_LEN = 16;

   localparam logic [7:0] HEAD0      = 8'hF1;
   localparam logic [7:0] HEAD1      = 8'hDD;
   localparam logic [7:0] ADDR_BYTES = 8'd4;

   // record preamble bytes
   localparam logic [7:0] REC_TYPE   = 8'd1;
   localparam logic [7:0] REC_ID_LEN = 8'd2;

   // result queue sizing
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   typedef logic [7:0] byte_type;
   typedef logic [6:0] left_type;

   typedef enum logic [7:0] {
      PH_HUNT0 = 8'b0000_0001,
      PH_HUNT1 = 8'b0000_0010,
      PH_LEN   = 8'b0000_0100,
      PH_SRC0  = 8'b0000_1000,
      PH_SRC1  = 8'b0001_0000,
      PH_DST0  = 8'b0010_0000,
      PH_DST1  = 8'b0100_0000,
      PH_PAY   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      byte_type data;
      logic     eor;
   } entry_type;

endpackage

// ===== rtl/core/mesh_frame_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_frame_deframer_core
// Hunts for the F1 DD header in a received byte stream and turns each frame
// into a record: type, id length, message length, sender id, payload.
// Results are written into the registered result queue and offered from its head.
// Throughput: one request per cycle while req_stall is low; a valid length byte queues three results.
// req_stall rises while the four-entry result queue lacks room for a request.
// Reset (synchronous): phase returns to hunting, the queue empties at once.
// ----------------------------------------------------------------------------
module mesh_frame_deframer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mfd_pkg::byte_type req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mfd_pkg::byte_type rsp_out_byte,
   output logic             rsp_end_of_record
);
   import mfd_pkg::*;

   phase_type           phase_ff, phase_in;
   left_type            left_ff, left_in;
   entry_type           queue_ff [QDEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   logic                req_take;
   logic                rsp_take;
   logic [1:0]          push_cnt;
   entry_type           push_ent [3];
   left_type            left_dec;
   logic                len_ok;
   phase_type           hunt_ph;

   // room check: a length byte may need three slots, others at most one
   assign req_stall = (count_ff > QCNT_W'(QDEPTH - 1)) ||
                      ((phase_ff == PH_LEN) && (count_ff > QCNT_W'(QDEPTH - 3)));
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   // frame decode
   assign hunt_ph  = (req_rx_byte == HEAD0) ? PH_HUNT1 : PH_HUNT0;
   assign len_ok   = (req_rx_byte >= ADDR_BYTES) &&
                     (req_rx_byte <= 8'(MAX_FRAME_LEN));
   assign left_dec = left_ff - 7'd1;

   always_comb begin
      phase_in    = phase_ff;
      left_in     = left_ff;
      push_cnt    = 2'd0;
      push_ent[0] = '{data: req_rx_byte, eor: 1'b0};
      push_ent[1] = '{data: REC_ID_LEN, eor: 1'b0};
      push_ent[2] = '{data: '0, eor: 1'b0};
      unique case (phase_ff)
         PH_HUNT0: phase_in = hunt_ph;
         PH_HUNT1: begin
            phase_in = (req_rx_byte == HEAD1) ? PH_LEN : hunt_ph;
         end
         PH_LEN: begin
            if (len_ok) begin
               left_in     = 7'(req_rx_byte - ADDR_BYTES);
               push_cnt    = 2'd3;
               push_ent[0] = '{data: REC_TYPE, eor: 1'b0};
               push_ent[1] = '{data: REC_ID_LEN, eor: 1'b0};
               push_ent[2] = '{data: 8'(7'(req_rx_byte - ADDR_BYTES)), eor: 1'b0};
               phase_in    = PH_SRC0;
            end else begin
               phase_in = hunt_ph;
            end
         end
         PH_SRC0: begin
            push_cnt = 2'd1;
            phase_in = PH_SRC1;
         end
         PH_SRC1: begin
            push_cnt    = 2'd1;
            push_ent[0] = '{data: req_rx_byte, eor: (left_ff == '0)};
            phase_in    = PH_DST0;
         end
         PH_DST0: phase_in = PH_DST1;
         PH_DST1: phase_in = (left_ff == '0) ? PH_HUNT0 : PH_PAY;
         PH_PAY: begin
            if (left_ff == '0) begin
               phase_in = hunt_ph;
            end else begin
               left_in     = left_dec;
               push_cnt    = 2'd1;
               push_ent[0] = '{data: req_rx_byte, eor: (left_dec == '0)};
               if (left_dec == '0) begin
                  phase_in = PH_HUNT0;
               end
            end
         end
         default: phase_in = PH_HUNT0;
      endcase
      if (!req_take) begin
         phase_in = phase_ff;
         left_in  = left_ff;
         push_cnt = 2'd0;
      end
   end

   // queue pointers
   assign tail_in  = tail_ff + QPTR_W'(push_cnt);
   assign head_in  = head_ff + QPTR_W'(rsp_take);
   assign count_in = count_ff + QCNT_W'(push_cnt) - QCNT_W'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT0;
         left_ff  <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // queue storage, up to three writes per cycle at the tail
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push_cnt) begin
            queue_ff[tail_ff + QPTR_W'(i)] <= push_ent[i];
         end
      end
   end

   // result port
   assign rsp_valid         = (count_ff != '0);
   assign rsp_out_byte      = queue_ff[head_ff].data;
   assign rsp_end_of_record = queue_ff[head_ff].eor;

endmodule

// ===== rtl/core/mfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_checker
// Port-level assertions for the mesh frame deframer core, bound to the core.
// ----------------------------------------------------------------------------
module mfd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input mfd_pkg::byte_type req_rx_byte,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mfd_pkg::byte_type rsp_out_byte,
   input logic             rsp_end_of_record
);
   import mfd_pkg::*;

   logic rec_start_ff, rec_start_in;
   logic rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   // next delivered result opens a record
   assign rec_start_in = rsp_take ? rsp_end_of_record : rec_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_start_ff <= 1'b1;
      end else begin
         rec_start_ff <= rec_start_in;
      end
   end

   // every record begins with the type byte
   a_rec_type: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rec_start_ff) |-> (rsp_out_byte == REC_TYPE))
      else $error("record does not open with type byte");

   // reset empties the result queue
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // an empty queue always has room for a request
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty result queue");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_end_of_record)))
      else $error("stalled result changed");

endmodule

bind mesh_frame_deframer_core mfd_checker u_mfd_checker (.*);
